@@ sv/aaco_pkg.sv @@
// Package for the camera orbit block: fixed-point types, stage numbers,
// constants and the CORDIC angle table. Depends on nothing.
`default_nettype none
package aaco_pkg;

  // Angle handling, units of 1/128 degree
  localparam int FULL_TURN    = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;

  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 32;
  localparam int QUOT_BITS    = 17;
  localparam logic signed [31:0] CORDIC_START = 32'sd652032874;
  localparam logic signed [18:0] ONE_Q16      = 19'sd65536;
  localparam logic signed [63:0] OUT_MAX      = 64'sd8388607;
  localparam logic signed [63:0] OUT_MIN      = -64'sd8388608;

  // Pipeline stage numbers
  localparam int ST_IN    = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_AXIS  = 2;
  localparam int ST_MAG   = 3;
  localparam int ST_MAX   = 4;
  localparam int ST_LEAD  = 5;
  localparam int ST_SHIFT = 6;
  localparam int ST_SQ    = 7;
  localparam int ST_SUM   = 8;
  localparam int ST_SQRT  = 9;
  localparam int ST_TRIG  = ST_SQRT + CORDIC_STEPS;
  localparam int ST_DIVS  = ST_SQRT + SQRT_STEPS;
  localparam int ST_DIV   = ST_DIVS + 1;
  localparam int ST_KFIN  = ST_DIV + QUOT_BITS;
  localparam int ST_R1    = ST_KFIN + 1;
  localparam int ST_R2    = ST_R1 + 1;
  localparam int ST_R3    = ST_R2 + 1;
  localparam int ST_R4    = ST_R3 + 1;
  localparam int ST_R5    = ST_R4 + 1;
  localparam int ST_OUT   = ST_R5 + 1;
  localparam int NSTG     = ST_OUT + 1;

  typedef logic signed [23:0] vec_t;
  typedef logic signed [16:0] ang_t;
  typedef logic signed [23:0] zang_t;
  typedef logic signed [31:0] cord_t;
  typedef logic signed [47:0] prd_t;
  typedef logic signed [48:0] ax_t;
  typedef logic signed [30:0] tn_t;
  typedef logic signed [17:0] sc_t;
  typedef logic signed [18:0] omc_t;
  typedef logic signed [41:0] p42_t;
  typedef logic signed [42:0] cr_t;
  typedef logic signed [27:0] kv_t;
  typedef logic signed [45:0] kkv_t;
  typedef logic signed [60:0] crs_t;
  typedef logic signed [63:0] acc_t;

  // Everything one item carries down the pipeline
  typedef struct packed {
    logic                  op;
    logic                  deg;
    logic                  flip;
    ang_t                  ang;
    vec_t [2:0]            eye;
    vec_t [2:0]            up;
    zang_t                 z;
    cord_t                 cx;
    cord_t                 cy;
    prd_t [5:0]            prd;
    ax_t  [2:0]            ax;
    logic [2:0][47:0]      am;
    logic [47:0]           mx;
    logic [5:0]            nb;
    tn_t  [2:0]            t;
    logic [2:0][59:0]      sq;
    logic [63:0]           sqv;
    logic [63:0]           sqr;
    logic [2:0][48:0]      rem;
    logic [2:0][16:0]      q;
    logic [31:0]           dv;
    sc_t                   cs;
    sc_t                   sn;
    omc_t                  omc;
    sc_t  [2:0]            k;
    p42_t [1:0][2:0]       kvp;
    p42_t [1:0][5:0]       crp;
    p42_t [1:0][2:0]       vc;
    kv_t  [1:0]            kv;
    cr_t  [1:0][2:0]       cr;
    kkv_t [1:0][2:0]       kkv;
    crs_t [1:0][2:0]       crs;
    acc_t [1:0][2:0]       kkvo;
    acc_t [1:0][2:0]       acc;
    vec_t [1:0][2:0]       res;
  } stage_t;

  // atan(2^-i) in units of 1/32768 degree
  function automatic zang_t atan_val(input logic [3:0] idx);
    zang_t v;
    case (idx)
      4'd0:    v = 24'sd1474560;
      4'd1:    v = 24'sd870484;
      4'd2:    v = 24'sd459940;
      4'd3:    v = 24'sd233473;
      4'd4:    v = 24'sd117189;
      4'd5:    v = 24'sd58652;
      4'd6:    v = 24'sd29333;
      4'd7:    v = 24'sd14667;
      4'd8:    v = 24'sd7334;
      4'd9:    v = 24'sd3667;
      4'd10:   v = 24'sd1833;
      4'd11:   v = 24'sd917;
      4'd12:   v = 24'sd458;
      4'd13:   v = 24'sd229;
      4'd14:   v = 24'sd115;
      default: v = 24'sd57;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ sv/axis_angle_camera_orbit.sv @@
// Camera orbit by axis-angle (Rodrigues) rotation, fully pipelined.
// Depends on aaco_pkg for types, stage numbers and the CORDIC table.
//
//   channel | ports                           | dir | handshake
//   in      | in_opcode, in_angle, in_eye_*,  | in  | in_valid / in_ready
//           | in_up_*                         |     |
//   out     | out_new_eye_*, out_new_up_*,    | out | out_valid / out_ready
//           | out_axis_degenerate             |     |
//
// One beat enters per cycle unless a stalled output has filled every stage. The depth
// to the output register is set by the 32-step square root and the 17-bit
// restoring divide, one step per stage; CORDIC runs beside the root.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// A stalled output holds the last stage; upstream stages keep moving into
// empty stages, so in_ready stays high while any stage is empty.
`default_nettype none
module axis_angle_camera_orbit
  import aaco_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire ang_t        in_angle,
  input  wire vec_t        in_eye_x,
  input  wire vec_t        in_eye_y,
  input  wire vec_t        in_eye_z,
  input  wire vec_t        in_up_x,
  input  wire vec_t        in_up_y,
  input  wire vec_t        in_up_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output vec_t             out_new_eye_x,
  output vec_t             out_new_eye_y,
  output vec_t             out_new_eye_z,
  output vec_t             out_new_up_x,
  output vec_t             out_new_up_y,
  output vec_t             out_new_up_z,
  output logic             out_axis_degenerate
);

  // Work of one stage on the item coming from the stage before
  function automatic stage_t step_fn(input int idx, input stage_t p);
    stage_t             s;
    logic signed [17:0] r;
    cord_t              dx, dy, xr, yr;
    logic [63:0]        sb, srb;
    logic [48:0]        dsh;
    logic signed [61:0] sqt;
    logic signed [43:0] ksum;
    logic signed [63:0] vcl, rr;
    tn_t                at;
    sc_t                qx;
    vec_t [2:0]         v;
    int                 j;
    s = p;
    // Cross products for the orbit-up axis, reduce the angle
    if (idx == ST_PROD) begin
      s.prd[0] = p.eye[1] * p.up[2];
      s.prd[1] = p.eye[2] * p.up[1];
      s.prd[2] = p.eye[2] * p.up[0];
      s.prd[3] = p.eye[0] * p.up[2];
      s.prd[4] = p.eye[0] * p.up[1];
      s.prd[5] = p.eye[1] * p.up[0];
      r = 18'(p.ang);
      if (r >= 18'(FULL_TURN)) r = r - 18'(FULL_TURN);
      if (r <= -18'(FULL_TURN)) r = r + 18'(FULL_TURN);
      if (r < 0) r = r + 18'(FULL_TURN);
      if (r > 18'(HALF_TURN)) r = r - 18'(FULL_TURN);
      s.flip = 1'b0;
      if (r > 18'(QUARTER_TURN)) begin
        r = r - 18'(HALF_TURN);
        s.flip = 1'b1;
      end else if (r < -18'(QUARTER_TURN)) begin
        r = r + 18'(HALF_TURN);
        s.flip = 1'b1;
      end
      s.z  = zang_t'(r) <<< 8;
      s.cx = CORDIC_START;
      s.cy = '0;
    end
    // Pick the axis
    if (idx == ST_AXIS) begin
      s.ax[0] = p.op ? ax_t'(p.prd[0]) - ax_t'(p.prd[1]) : ax_t'(p.up[0]);
      s.ax[1] = p.op ? ax_t'(p.prd[2]) - ax_t'(p.prd[3]) : ax_t'(p.up[1]);
      s.ax[2] = p.op ? ax_t'(p.prd[4]) - ax_t'(p.prd[5]) : ax_t'(p.up[2]);
    end
    if (idx == ST_MAG) begin
      for (int i = 0; i < 3; i++) begin
        s.am[i] = p.ax[i][48] ? 48'(-p.ax[i]) : 48'(p.ax[i]);
      end
    end
    if (idx == ST_MAX) begin
      s.mx = p.am[0];
      if (p.am[1] > s.mx) s.mx = p.am[1];
      if (p.am[2] > s.mx) s.mx = p.am[2];
    end
    // Bit length of the largest component
    if (idx == ST_LEAD) begin
      s.nb = '0;
      for (int b = 0; b < 48; b++) begin
        if (p.mx[b]) s.nb = 6'(b + 1);
      end
      s.deg = (p.mx == '0);
    end
    // Scale the axis so the largest magnitude has 30 bits
    if (idx == ST_SHIFT) begin
      for (int i = 0; i < 3; i++) begin
        if (p.nb > 6'd30) s.t[i] = tn_t'(p.ax[i] >>> (p.nb - 6'd30));
        else s.t[i] = tn_t'(p.ax[i] <<< (6'd30 - p.nb));
      end
    end
    if (idx == ST_SQ) begin
      for (int i = 0; i < 3; i++) begin
        sqt = p.t[i] * p.t[i];
        s.sq[i] = sqt[59:0];
      end
    end
    if (idx == ST_SUM) begin
      s.sqv = {4'b0, p.sq[0]} + {4'b0, p.sq[1]} + {4'b0, p.sq[2]};
      s.sqr = '0;
    end
    // One square root step
    if (idx >= ST_SQRT && idx < ST_SQRT + SQRT_STEPS) begin
      j = idx - ST_SQRT;
      sb = 64'd1 << (62 - 2 * j);
      srb = p.sqr + sb;
      if (p.sqv >= srb) begin
        s.sqv = p.sqv - srb;
        s.sqr = (p.sqr >> 1) + sb;
      end else begin
        s.sqr = p.sqr >> 1;
      end
    end
    // One CORDIC rotation
    if (idx >= ST_SQRT && idx < ST_SQRT + CORDIC_STEPS) begin
      j = idx - ST_SQRT;
      dx = p.cy >>> j;
      dy = p.cx >>> j;
      if (!p.z[23]) begin
        s.cx = p.cx - dx;
        s.cy = p.cy + dy;
        s.z  = p.z - atan_val(4'(j));
      end else begin
        s.cx = p.cx + dx;
        s.cy = p.cy - dy;
        s.z  = p.z + atan_val(4'(j));
      end
    end
    // Round sine and cosine to Q16, undo the half-turn move
    if (idx == ST_TRIG) begin
      xr = (p.cx + 32'sd8192) >>> 14;
      yr = (p.cy + 32'sd8192) >>> 14;
      s.cs = sc_t'(p.flip ? -xr : xr);
      s.sn = sc_t'(p.flip ? -yr : yr);
      s.omc = ONE_Q16 - omc_t'(s.cs);
    end
    // Set up the divides |t|*2^17 + len over 2*len
    if (idx == ST_DIVS) begin
      s.dv = {p.sqr[30:0], 1'b0};
      for (int i = 0; i < 3; i++) begin
        at = p.t[i][30] ? -p.t[i] : p.t[i];
        s.rem[i] = ({18'b0, at} << 17) + {18'b0, p.sqr[30:0]};
        s.q[i] = '0;
      end
    end
    // One quotient bit per divide
    if (idx >= ST_DIV && idx < ST_DIV + QUOT_BITS) begin
      j = QUOT_BITS - 1 - (idx - ST_DIV);
      dsh = {17'b0, p.dv} << j;
      for (int i = 0; i < 3; i++) begin
        if (p.rem[i] >= dsh) begin
          s.rem[i] = p.rem[i] - dsh;
          s.q[i][j] = 1'b1;
        end
      end
    end
    if (idx == ST_KFIN) begin
      for (int i = 0; i < 3; i++) begin
        qx = sc_t'({1'b0, p.q[i]});
        s.k[i] = p.t[i][30] ? -qx : qx;
      end
    end
    // Rodrigues terms; w = 0 is eye, w = 1 is up
    for (int w = 0; w < 2; w++) begin
      v = w[0] ? p.up : p.eye;
      if (idx == ST_R1) begin
        for (int i = 0; i < 3; i++) begin
          s.kvp[w][i] = p.k[i] * v[i];
          s.vc[w][i]  = v[i] * p.cs;
        end
        s.crp[w][0] = p.k[1] * v[2];
        s.crp[w][1] = p.k[2] * v[1];
        s.crp[w][2] = p.k[2] * v[0];
        s.crp[w][3] = p.k[0] * v[2];
        s.crp[w][4] = p.k[0] * v[1];
        s.crp[w][5] = p.k[1] * v[0];
      end
      if (idx == ST_R2) begin
        ksum = p.kvp[w][0] + p.kvp[w][1] + p.kvp[w][2];
        s.kv[w] = kv_t'((ksum + 44'sd32768) >>> 16);
        s.cr[w][0] = p.crp[w][0] - p.crp[w][1];
        s.cr[w][1] = p.crp[w][2] - p.crp[w][3];
        s.cr[w][2] = p.crp[w][4] - p.crp[w][5];
      end
      if (idx == ST_R3) begin
        for (int i = 0; i < 3; i++) begin
          s.kkv[w][i] = p.k[i] * p.kv[w];
          s.crs[w][i] = p.cr[w][i] * p.sn;
        end
      end
      if (idx == ST_R4) begin
        for (int i = 0; i < 3; i++) begin
          s.kkvo[w][i] = p.kkv[w][i] * p.omc;
        end
      end
      if (idx == ST_R5) begin
        for (int i = 0; i < 3; i++) begin
          vcl = p.vc[w][i];
          s.acc[w][i] = (vcl <<< 16) + p.crs[w][i] + p.kkvo[w][i];
        end
      end
      // Round to Q8.16, saturate, pass through on a zero axis
      if (idx == ST_OUT) begin
        for (int i = 0; i < 3; i++) begin
          rr = (p.acc[w][i] + 64'sd2147483648) >>> 32;
          if (p.deg) s.res[w][i] = v[i];
          else if (rr > OUT_MAX) s.res[w][i] = vec_t'(OUT_MAX);
          else if (rr < OUT_MIN) s.res[w][i] = vec_t'(OUT_MIN);
          else s.res[w][i] = vec_t'(rr);
        end
      end
    end
    return s;
  endfunction

  stage_t             stg_r   [NSTG];
  stage_t             stg_nxt [NSTG];
  logic   [NSTG-1:0]  vld_r;
  logic   [NSTG-1:0]  vld_nxt;
  logic   [NSTG-1:0]  en;
  stage_t             in_stg;

  // Pack the input beat
  always_comb begin
    in_stg     = '0;
    in_stg.op  = in_opcode;
    in_stg.ang = in_angle;
    in_stg.eye = {in_eye_z, in_eye_y, in_eye_x};
    in_stg.up  = {in_up_z, in_up_y, in_up_x};
  end

  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_stg
      // A stage advances when it or any stage below it has room
      assign en[g] = out_ready || !(&vld_r[NSTG-1:g]);
      if (g == ST_IN) begin : g_first
        assign stg_nxt[g] = in_stg;
        assign vld_nxt[g] = in_valid;
      end else begin : g_rest
        assign stg_nxt[g] = step_fn(g, stg_r[g-1]);
        assign vld_nxt[g] = vld_r[g-1];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (en[g]) begin
          vld_r[g] <= vld_nxt[g];
        end
      end
      always_ff @(posedge clk) begin
        if (en[g]) begin
          stg_r[g] <= stg_nxt[g];
        end
      end
    end
  endgenerate

  // Drive the ports
  assign in_ready            = en[ST_IN];
  assign out_valid           = vld_r[ST_OUT];
  assign out_new_eye_x       = stg_r[ST_OUT].res[0][0];
  assign out_new_eye_y       = stg_r[ST_OUT].res[0][1];
  assign out_new_eye_z       = stg_r[ST_OUT].res[0][2];
  assign out_new_up_x        = stg_r[ST_OUT].res[1][0];
  assign out_new_up_y        = stg_r[ST_OUT].res[1][1];
  assign out_new_up_z        = stg_r[ST_OUT].res[1][2];
  assign out_axis_degenerate = stg_r[ST_OUT].deg;

  // Checks
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while output side is ready");

  a_bubble_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[ST_IN] |-> in_ready)
    else $error("empty first stage refused a beat");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[ST_IN])
    else $error("accepted beat did not reach the first stage");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_ready && (&vld_r)) |-> !in_ready)
    else $error("full stalled pipeline took a beat");

endmodule
`default_nettype wire

@@ tb/axis_angle_camera_orbit_tb.sv @@
// Testbench for the camera orbit block: directed and random orbit beats checked
// against a built-in fixed-point Rodrigues predictor. Depends on aaco_pkg and the RTL.
`timescale 1ns / 100ps
module axis_angle_camera_orbit_tb
  import aaco_pkg::*;
();

  typedef struct {
    logic op;
    longint ang;
    longint eye[3];
    longint up[3];
  } orbit_in_t;

  typedef struct {
    longint ne[3];
    longint nu[3];
    logic deg;
  } orbit_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = 1'b0;
  ang_t in_angle = '0;
  vec_t in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  vec_t in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vec_t out_new_eye_x, out_new_eye_y, out_new_eye_z;
  vec_t out_new_up_x, out_new_up_y, out_new_up_z;
  logic out_axis_degenerate;

  orbit_res_t pending_orbits[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int degenerate_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  axis_angle_camera_orbit u_dut (.*);

  always #5 clk = ~clk;

  // floor shift and round-half-up shift
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint atan_step(int i);
    longint tab[16] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
                        7334, 3667, 1833, 917, 458, 229, 115, 57};
    return tab[i];
  endfunction

  // sine and cosine at scale 2^16 from an angle in 1/128 degree
  function automatic void trig_of(input longint ang, output longint sn, output longint cs);
    longint r, x, y, z, dx, dy;
    bit flip;
    r = ang % FULL_TURN;
    x = CORDIC_START;
    y = 0;
    flip = 0;
    if (r < 0) r += FULL_TURN;
    if (r > HALF_TURN) r -= FULL_TURN;
    if (r > QUARTER_TURN) begin
      r -= HALF_TURN;
      flip = 1;
    end else if (r < -QUARTER_TURN) begin
      r += HALF_TURN;
      flip = 1;
    end
    z = r * 256;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    x = rshr(x, 14);
    y = rshr(y, 14);
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic void spin_vec(input longint k[3], input longint c, input longint s,
                                   input longint v[3], output longint o[3]);
    longint kv, cr[3];
    kv = rshr(k[0] * v[0] + k[1] * v[1] + k[2] * v[2], 16);
    cr[0] = k[1] * v[2] - k[2] * v[1];
    cr[1] = k[2] * v[0] - k[0] * v[2];
    cr[2] = k[0] * v[1] - k[1] * v[0];
    for (int i = 0; i < 3; i++)
      o[i] = sat24(rshr(v[i] * c * 65536 + cr[i] * s + k[i] * kv * (65536 - c), 32));
  endfunction

  // expected rotated eye/up for one beat
  function automatic orbit_res_t predict_orbit(orbit_in_t it);
    orbit_res_t r;
    longint ax[3], t[3], k[3], m, len, q, sn, cs;
    longint unsigned len2;
    int n;
    if (it.op) begin
      ax[0] = it.eye[1] * it.up[2] - it.eye[2] * it.up[1];
      ax[1] = it.eye[2] * it.up[0] - it.eye[0] * it.up[2];
      ax[2] = it.eye[0] * it.up[1] - it.eye[1] * it.up[0];
    end else begin
      ax = it.up;
    end
    m = absl(ax[0]);
    if (absl(ax[1]) > m) m = absl(ax[1]);
    if (absl(ax[2]) > m) m = absl(ax[2]);
    if (m == 0) begin
      r.ne = it.eye;
      r.nu = it.up;
      r.deg = 1'b1;
      return r;
    end
    n = 0;
    while ((m >> n) != 0) n++;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = (n > 30) ? fshr(ax[i], n - 30) : ax[i] * (longint'(1) << (30 - n));
      len2 += longint'(t[i] * t[i]);
    end
    len = root_floor(len2);
    for (int i = 0; i < 3; i++) begin
      q = (absl(t[i]) * 131072 + len) / (2 * len);
      k[i] = t[i] < 0 ? -q : q;
    end
    trig_of(it.ang, sn, cs);
    spin_vec(k, cs, sn, it.eye, r.ne);
    spin_vec(k, cs, sn, it.up, r.nu);
    r.deg = 1'b0;
    return r;
  endfunction

  // drive one beat and hold it until accepted
  task automatic send_orbit(input orbit_in_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_opcode <= it.op;
    in_angle <= ang_t'(it.ang);
    in_eye_x <= vec_t'(it.eye[0]);
    in_eye_y <= vec_t'(it.eye[1]);
    in_eye_z <= vec_t'(it.eye[2]);
    in_up_x <= vec_t'(it.up[0]);
    in_up_y <= vec_t'(it.up[1]);
    in_up_z <= vec_t'(it.up[2]);
    in_valid <= 1'b1;
    pending_orbits.push_back(predict_orbit(it));
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic longint rand_vec_c();
    case ($urandom_range(4))
      0: return $urandom_range(1) ? 8388607 : -8388608;
      1: return longint'($urandom_range(131072)) - 65536;
      2: return 0;
      default: return longint'($signed(24'($urandom)));
    endcase
  endfunction

  function automatic orbit_in_t rand_orbit();
    orbit_in_t it;
    it.op = $urandom_range(1);
    it.ang = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 46080 : -46080)
                                      : longint'($urandom_range(92160)) - 46080;
    for (int i = 0; i < 3; i++) begin
      it.eye[i] = rand_vec_c();
      it.up[i] = rand_vec_c();
    end
    if ($urandom_range(15) == 0) it.up = '{0, 0, 0};
    if ($urandom_range(15) == 0) it.eye = it.up;
    return it;
  endfunction

  function automatic orbit_in_t mk(logic op, longint ang, longint ex, longint ey, longint ez,
                                   longint ux, longint uy, longint uz);
    orbit_in_t it;
    it.op = op; it.ang = ang;
    it.eye = '{ex, ey, ez};
    it.up = '{ux, uy, uz};
    return it;
  endfunction

  // receiver stall on the falling edge
  always @(negedge clk)
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    orbit_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_orbits.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = pending_orbits.pop_front();
        beats_checked++;
        if (out_axis_degenerate) degenerate_seen++;
        if (out_new_eye_x !== vec_t'(e.ne[0])) begin
          $error("new_eye_x exp %0d got %0d", e.ne[0], out_new_eye_x); errors++; end
        if (out_new_eye_y !== vec_t'(e.ne[1])) begin
          $error("new_eye_y exp %0d got %0d", e.ne[1], out_new_eye_y); errors++; end
        if (out_new_eye_z !== vec_t'(e.ne[2])) begin
          $error("new_eye_z exp %0d got %0d", e.ne[2], out_new_eye_z); errors++; end
        if (out_new_up_x !== vec_t'(e.nu[0])) begin
          $error("new_up_x exp %0d got %0d", e.nu[0], out_new_up_x); errors++; end
        if (out_new_up_y !== vec_t'(e.nu[1])) begin
          $error("new_up_y exp %0d got %0d", e.nu[1], out_new_up_y); errors++; end
        if (out_new_up_z !== vec_t'(e.nu[2])) begin
          $error("new_up_z exp %0d got %0d", e.nu[2], out_new_up_z); errors++; end
        if (out_axis_degenerate !== e.deg) begin
          $error("axis_degenerate exp %0d got %0d", e.deg, out_axis_degenerate); errors++; end
      end
    end
  end

  task automatic test_directed();
    send_orbit(mk(0, 0, 65536, 0, 0, 0, 65536, 0));
    send_orbit(mk(0, 11520, 65536, 0, 0, 0, 65536, 0));
    send_orbit(mk(1, 11520, 0, 0, 65536, 0, 65536, 0));
    send_orbit(mk(0, 46080, 65536, 65536, 0, 0, 0, 65536));
    send_orbit(mk(1, -46080, 65536, 0, 65536, 0, 65536, 0));
    send_orbit(mk(0, 23040, 100000, -5000, 7, 1, 2, 3));
    send_orbit(mk(0, -23040, 3, 2, 1, 0, 0, -1));
    send_orbit(mk(1, 23041, 131072, 0, 0, 0, 131072, 0));
    send_orbit(mk(0, -11521, 1, 1, 1, 0, 0, 0));
    send_orbit(mk(1, 5000, 65536, 0, 0, 131072, 0, 0));
    send_orbit(mk(1, 300, 0, 0, 0, 0, 65536, 0));
    send_orbit(mk(0, 11520, 8388607, 8388607, 8388607, -8388608, 8388607, 0));
    send_orbit(mk(1, -11520, -8388608, -8388608, -8388608, 8388607, -8388608, 8388607));
    send_orbit(mk(0, 65535, -8388608, 8388607, -1, 8388607, 8388607, 8388607));
    send_orbit(mk(1, -65536, 8388607, -8388608, 1, -8388608, 1, -1));
    send_orbit(mk(0, 3000, 0, 0, 8388607, 0, 0, -8388608));
    send_orbit(mk(1, 17000, 1, 0, 0, 0, 1, 0));
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_orbit(rand_orbit());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(140, 0, 0);
    test_random(140, 69, 0);
    test_random(140, 0, 69);
    test_random(140, 30, 30);
    send_idle_pct = 0;
    in_valid <= 1'b0;
    while (pending_orbits.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d orbit beats, checked %0d results (%0d with a zero-length axis).",
             beats_sent, beats_checked, degenerate_seen);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
